// ----- design/lksc_pkg.sv -----
package lksc_pkg;

   // Largest register length the block is built for, the fixed byte geometry and the CSR field widths.
   localparam int MAX_REGISTER_BITS_DEF = 64;
   localparam int STEPS_PER_BYTE        = 8;
   localparam int BYTE_BITS             = 8;
   localparam int CSR_WIDTH             = 64;
   localparam int LENGTH_WIDTH          = 7;
   localparam int CSR_INDEX_WIDTH       = 2;

   typedef enum logic [2:0] {
      OP_CIPHER  = 3'd0,
      OP_LOAD    = 3'd1,
      OP_MIX     = 3'd2,
      OP_SAVE    = 3'd3,
      OP_RESTART = 3'd4
   } op_type;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_SEED   = 2'd0,
      CSR_TAPS   = 2'd1,
      CSR_LENGTH = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [2:0]           opcode;
      logic [BYTE_BITS-1:0] data_byte;
      logic [2:0]           byte_position;
   } req_type;

   typedef struct packed {
      logic [BYTE_BITS-1:0] result_byte;
      logic                 status;
   } rsp_type;

   // Per-beat commands broadcast to every cell of the register.
   typedef struct packed {
      logic step;
      logic load;
      logic mix;
      logic save;
      logic restart;
   } cell_ctrl_type;

endpackage

// ----- design/lksc_cell.sv -----
module lksc_cell
   import lksc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctrl_type ctrl,
   input  logic          in_use,
   input  logic          chain_bit,
   input  logic          seed_bit,
   input  logic          salt_bit,
   output logic          state_bit
);

   logic shift_ff, shift_in;
   logic restart_ff, restart_in;

   // Bits above the active length always read as zero.
   assign state_bit = shift_ff & in_use;

   always_comb begin
      shift_in = shift_ff;
      if (ctrl.step) begin
         shift_in = chain_bit & in_use;
      end else if (ctrl.load) begin
         shift_in = seed_bit & in_use;
      end else if (ctrl.mix) begin
         shift_in = (shift_ff ^ salt_bit) & in_use;
      end else if (ctrl.restart) begin
         shift_in = restart_ff & in_use;
      end
      restart_in = ctrl.save ? state_bit : restart_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         shift_ff   <= 1'b0;
         restart_ff <= 1'b0;
      end else begin
         shift_ff   <= shift_in;
         restart_ff <= restart_in;
      end
   end

endmodule

// ----- design/lksc_feedback.sv -----
module lksc_feedback
   import lksc_pkg::*;
#(
   parameter int MAX_REGISTER_BITS = MAX_REGISTER_BITS_DEF
)
(
   input  logic [MAX_REGISTER_BITS-1:0]         state,
   input  logic [MAX_REGISTER_BITS-1:0]         taps,
   input  logic [$clog2(MAX_REGISTER_BITS)-1:0] top_position,
   output logic [STEPS_PER_BYTE-1:0]            low_bits,
   output logic [BYTE_BITS-1:0]                 pad_byte
);

   localparam int WORD_BITS = MAX_REGISTER_BITS + STEPS_PER_BYTE;
   localparam int WI        = $clog2(WORD_BITS);

   logic [STEPS_PER_BYTE-1:0]    partial;
   logic [STEPS_PER_BYTE-1:0]    fb;
   logic [WORD_BITS-1:0]         word;
   logic [WI-1:0]                idx [STEPS_PER_BYTE];

   // Parity of the taps over the register bits that survive k shifts; these
   // are independent of each other.
   always_comb begin
      for (int k = 0; k < STEPS_PER_BYTE; k++) begin
         partial[k] = ^(taps & (state << k));
      end
   end

   // The feedback bits of earlier steps sit in the low positions after k
   // shifts, so each step adds the tapped ones of those to its parity.
   always_comb begin
      for (int k = 0; k < STEPS_PER_BYTE; k++) begin
         fb[k] = partial[k];
         for (int q = 0; q < k; q++) begin
            fb[k] = fb[k] ^ (taps[q] & fb[k-1-q]);
         end
      end
   end

   // The feedback bit of step m lands at bit STEPS_PER_BYTE-1-m of the new state.
   always_comb begin
      for (int j = 0; j < STEPS_PER_BYTE; j++) begin
         low_bits[j] = fb[STEPS_PER_BYTE-1-j];
      end
   end

   // After k steps, position p holds word[p + STEPS_PER_BYTE - k].
   assign word = {state, low_bits};

   always_comb begin
      for (int k = 0; k < STEPS_PER_BYTE; k++) begin
         idx[k] = WI'(top_position) + WI'(STEPS_PER_BYTE - k);
         pad_byte[BYTE_BITS-1-k] = word[idx[k]];
      end
   end

endmodule

// ----- design/lfsr_keystream_byte_cipher.sv -----
// LFSR keystream byte cipher: eight Fibonacci LFSR steps per cipher beat.
// A result enters the output register when that is free or being emptied, else the skid entry.
// Throughput: one beat per cycle while the skid entry is empty, set by the bit cells, which update once per beat;
// a two-entry output buffer lets one further request in while a result is stalled.
// Reset (synchronous, active high) clears the register, the restart point, the
// configuration registers (length back to its maximum) and the output buffer.
module lfsr_keystream_byte_cipher
   import lksc_pkg::*;
#(
   parameter int MAX_REGISTER_BITS = MAX_REGISTER_BITS_DEF
)
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  req_type                    req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output rsp_type                    rsp_data,
   input  logic                       csr_wen,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_WIDTH-1:0]       csr_wdata
);

   localparam int IDX_W = $clog2(MAX_REGISTER_BITS);

   // Configuration registers.
   logic [MAX_REGISTER_BITS-1:0] seed_ff;
   logic [MAX_REGISTER_BITS-1:0] taps_ff;
   logic [LENGTH_WIDTH-1:0]      length_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff   <= '0;
         taps_ff   <= '0;
         length_ff <= LENGTH_WIDTH'(MAX_REGISTER_BITS_DEF);
      end else if (csr_wen) begin
         case (csr_index)
            CSR_SEED:   seed_ff   <= csr_wdata[MAX_REGISTER_BITS-1:0];
            CSR_TAPS:   taps_ff   <= csr_wdata[MAX_REGISTER_BITS-1:0];
            CSR_LENGTH: length_ff <= csr_wdata[LENGTH_WIDTH-1:0];
            default: ;
         endcase
      end
   end

   // The written length is clamped to the range the register can hold; a
   // length of zero behaves as one bit.
   logic [LENGTH_WIDTH-1:0]      length_eff;
   logic [IDX_W-1:0]             top_position;
   logic [MAX_REGISTER_BITS-1:0] in_use;
   logic [MAX_REGISTER_BITS-1:0] taps_used;
   logic                         taps_empty;

   always_comb begin
      length_eff = length_ff;
      if (length_ff == '0) begin
         length_eff = LENGTH_WIDTH'(1);
      end else if (length_ff > LENGTH_WIDTH'(MAX_REGISTER_BITS)) begin
         length_eff = LENGTH_WIDTH'(MAX_REGISTER_BITS);
      end
   end

   assign top_position = IDX_W'(length_eff - LENGTH_WIDTH'(1));
   assign taps_used    = taps_ff & in_use;
   assign taps_empty   = (taps_used == '0);

   // A request beat is taken whenever the output buffer has a free entry.
   logic    accept;
   logic    pop;
   logic    out_valid_ff, out_valid_in;
   logic    skid_valid_ff, skid_valid_in;
   rsp_type out_ff, out_in;
   rsp_type skid_ff, skid_in;
   rsp_type rsp_new;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;
   assign pop       = out_valid_ff && rsp_ready;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // Decode the opcode into the commands every cell sees and into the response of the beat.
   cell_ctrl_type ctrl;
   logic [BYTE_BITS-1:0] pad_byte;

   always_comb begin
      ctrl    = '0;
      rsp_new = '0;
      case (req_data.opcode)
         OP_CIPHER: begin
            if (taps_empty) begin
               rsp_new.status = 1'b1;
            end else begin
               ctrl.step           = accept;
               rsp_new.result_byte = req_data.data_byte ^ pad_byte;
            end
         end
         OP_LOAD:    ctrl.load    = accept;
         OP_MIX:     ctrl.mix     = accept;
         OP_SAVE:    ctrl.save    = accept;
         OP_RESTART: ctrl.restart = accept;
         default: ;
      endcase
   end

   // The row of bit cells. Each cipher beat moves every bit up by eight
   // positions, so a cell takes its new bit from the cell eight below it; the
   // lowest eight cells take the feedback bits of the eight steps instead.
   logic [MAX_REGISTER_BITS-1:0] state;
   logic [STEPS_PER_BYTE-1:0]    low_bits;

   for (genvar i = 0; i < MAX_REGISTER_BITS; i++) begin : g_cell
      logic shift_in;
      logic salt_bit;

      assign in_use[i] = (LENGTH_WIDTH'(i) < length_eff);
      assign salt_bit  = (req_data.byte_position == 3'(i / BYTE_BITS)) ?
                         req_data.data_byte[i % BYTE_BITS] : 1'b0;

      if (i >= STEPS_PER_BYTE) begin : g_chain
         assign shift_in = state[i-STEPS_PER_BYTE];
      end else begin : g_low
         assign shift_in = low_bits[i];
      end

      lksc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .ctrl      (ctrl),
         .in_use    (in_use[i]),
         .chain_bit (shift_in),
         .seed_bit  (seed_ff[i]),
         .salt_bit  (salt_bit),
         .state_bit (state[i])
      );
   end

   // Feedback and keystream for the eight steps of one beat.
   lksc_feedback #(
      .MAX_REGISTER_BITS (MAX_REGISTER_BITS)
   ) u_feedback (
      .state        (state),
      .taps         (taps_used),
      .top_position (top_position),
      .low_bits     (low_bits),
      .pad_byte     (pad_byte)
   );

   // Output register with a skid entry behind it. A new result goes straight
   // to the output register when that is free or being emptied this cycle,
   // and otherwise waits in the skid entry.
   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || pop) begin
            out_in       = rsp_new;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = rsp_new;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule
